>>> src/neighbor_list_skin_tracker_defines.svh
// Assertion macros shared by the skin tracker RTL.
`ifndef NEIGHBOR_LIST_SKIN_TRACKER_DEFINES_SVH
`define NEIGHBOR_LIST_SKIN_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NLST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define NLST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/nlst_pkg.sv
// Types and constants of the neighbor list skin tracker.
package nlst_pkg;

  localparam int TOTAL_W = 32;
  localparam int IDX_W   = 10;
  localparam int ID_W    = IDX_W + 1;
  localparam int EPOCH_W = 8;

  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  localparam logic REQ_REBUILD = 1'b0;
  localparam logic REQ_MOVE    = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK
  } state_e;

endpackage

>>> src/nlst_ram.sv
// Generic single-port synchronous RAM with registered read data.
module nlst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/neighbor_list_skin_tracker.sv
// Neighbor list skin tracker: top level with the displacement memory and leader tracking.
//
// Keeps the accumulated displacement of every particle of two sets in one
// single-port memory (2*PARTICLES words of total plus epoch tag) and the two
// largest totals in registers. Every transfer on the input channel gives
// exactly one result transfer: list_valid, largest_total, second_total.
// A rebuild or an out-of-range move is answered straight from the idle state;
// an in-range move passes through memory read, read-modify-write with leader
// update and skin compare, as the memory has registered read data and a single
// port. A rebuild does not touch the memory: it bumps the epoch tag, so words
// with an older tag read as zero. After reset, and after every 255th rebuild
// when the tag wraps, a clearing pass writes all 2*PARTICLES words, one per
// cycle, during which in_stall_o stays high (config writes are still taken).
// Results sit in an output register; a result held by out_stall_i keeps the
// input stalled until it is taken. skin_margin is written through the cfg
// channel, which is always ready; write it only while the block is idle.
module neighbor_list_skin_tracker #(
  parameter int PARTICLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_skin_margin_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        from_first_set_i,
  input  logic [9:0]  particle_index_i,
  input  logic [31:0] displacement_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        list_valid_o,
  output logic [31:0] largest_total_o,
  output logic [31:0] second_total_o
);

  import nlst_pkg::*;

  localparam int DEPTH  = 2 * PARTICLES;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = EPOCH_W + TOTAL_W;

  // control state
  state_e               state_q, state_d;
  logic [AW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [EPOCH_W-1:0]   epoch_q, epoch_d;
  logic [TOTAL_W-1:0]   skin_margin_q;

  // tracking state
  logic [ID_W-1:0]      leader_id_q, leader_id_d;
  logic [ID_W-1:0]      runner_id_q, runner_id_d;
  logic [TOTAL_W-1:0]   leader_total_q, leader_total_d;
  logic [TOTAL_W-1:0]   runner_total_q, runner_total_d;
  logic                 valid_flag_q, valid_flag_d;

  // move held across the lookup
  logic [AW-1:0]        addr_q;
  logic [ID_W-1:0]      id_q;
  logic [TOTAL_W-1:0]   disp_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic                 out_list_valid_q, out_list_valid_d;
  logic [TOTAL_W-1:0]   out_largest_q, out_largest_d;
  logic [TOTAL_W-1:0]   out_second_q, out_second_d;

  // memory port
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_addr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  logic                 out_free;
  logic                 in_accept;
  logic                 in_range;
  logic [AW-1:0]        in_addr;
  logic [TOTAL_W-1:0]   old_total;
  logic [TOTAL_W:0]     add_sum;
  logic [TOTAL_W-1:0]   now_total;
  logic [TOTAL_W:0]     pair_sum;
  logic                 skin_ok;

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_range = 32'(particle_index_i) < 32'(PARTICLES);
  assign in_addr  = from_first_set_i ? AW'(PARTICLES) + AW'(particle_index_i)
                                     : AW'(particle_index_i);

  // stale epoch tag means the word was not written since the last rebuild
  assign old_total = (ram_rdata[WORD_W-1 -: EPOCH_W] == epoch_q)
                   ? ram_rdata[TOTAL_W-1:0] : '0;
  assign add_sum   = {1'b0, old_total} + {1'b0, disp_q};
  assign now_total = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];

  // 33-bit sum never wraps
  assign pair_sum = {1'b0, leader_total_q} + {1'b0, runner_total_q};
  assign skin_ok  = pair_sum < {1'b0, skin_margin_q};

  always_comb begin
    state_d          = state_q;
    clr_cnt_d        = clr_cnt_q;
    epoch_d          = epoch_q;
    leader_id_d      = leader_id_q;
    runner_id_d      = runner_id_q;
    leader_total_d   = leader_total_q;
    runner_total_d   = runner_total_q;
    valid_flag_d     = valid_flag_q;
    out_valid_d      = out_valid_q && out_stall_i;
    out_list_valid_d = out_list_valid_q;
    out_largest_d    = out_largest_q;
    out_second_d     = out_second_q;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_addr         = addr_q;
    ram_wdata        = {epoch_q, now_total};

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clr_cnt_d = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end

      ST_IDLE: begin
        ram_addr = in_addr;
        if (in_accept) begin
          if (req_type_i == REQ_REBUILD) begin
            leader_id_d      = '0;
            runner_id_d      = '0;
            leader_total_d   = '0;
            runner_total_d   = '0;
            valid_flag_d     = 1'b1;
            out_valid_d      = 1'b1;
            out_list_valid_d = 1'b1;
            out_largest_d    = '0;
            out_second_d     = '0;
            if (epoch_q == EPOCH_LAST) begin
              epoch_d = EPOCH_FIRST;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end else if (in_range) begin
            ram_re  = 1'b1;
            state_d = ST_LOOKUP;
          end else begin
            // out-of-range move: report state unchanged
            out_valid_d      = 1'b1;
            out_list_valid_d = valid_flag_q;
            out_largest_d    = leader_total_q;
            out_second_d     = runner_total_q;
          end
        end
      end

      ST_LOOKUP: begin
        ram_we  = 1'b1;
        state_d = ST_CHECK;
        if (id_q == leader_id_q) begin
          leader_total_d = now_total;
        end else if (id_q == runner_id_q) begin
          if (leader_total_q < now_total) begin
            leader_id_d    = runner_id_q;
            leader_total_d = now_total;
            runner_id_d    = leader_id_q;
            runner_total_d = leader_total_q;
          end else begin
            runner_total_d = now_total;
          end
        end else if (leader_total_q < now_total) begin
          runner_id_d    = leader_id_q;
          runner_total_d = leader_total_q;
          leader_id_d    = id_q;
          leader_total_d = now_total;
        end else if (runner_total_q < now_total) begin
          runner_id_d    = id_q;
          runner_total_d = now_total;
        end
      end

      ST_CHECK: begin
        if (out_free) begin
          valid_flag_d     = skin_ok;
          out_valid_d      = 1'b1;
          out_list_valid_d = skin_ok;
          out_largest_d    = leader_total_q;
          out_second_d     = runner_total_q;
          state_d          = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_cnt_q      <= '0;
      epoch_q        <= EPOCH_FIRST;
      skin_margin_q  <= '0;
      leader_id_q    <= '0;
      runner_id_q    <= '0;
      leader_total_q <= '0;
      runner_total_q <= '0;
      valid_flag_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_cnt_q      <= clr_cnt_d;
      epoch_q        <= epoch_d;
      leader_id_q    <= leader_id_d;
      runner_id_q    <= runner_id_d;
      leader_total_q <= leader_total_d;
      runner_total_q <= runner_total_d;
      valid_flag_q   <= valid_flag_d;
      out_valid_q    <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        skin_margin_q <= cfg_skin_margin_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q <= in_addr;
      id_q   <= {from_first_set_i, particle_index_i};
      disp_q <= displacement_i;
    end
    out_list_valid_q <= out_list_valid_d;
    out_largest_q    <= out_largest_d;
    out_second_q     <= out_second_d;
  end

  nlst_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign list_valid_o    = out_list_valid_q;
  assign largest_total_o = out_largest_q;
  assign second_total_o  = out_second_q;

`include "neighbor_list_skin_tracker_defines.svh"

  `NLST_ASSERT_SAME(a_no_accept_in_clear, state_q == ST_CLEAR, in_stall_o, "accept during clear pass")
  `NLST_ASSERT_SAME(a_leader_order, 1'b1, leader_total_q >= runner_total_q, "runner above leader")
  `NLST_ASSERT_SAME(a_distinct_ids, runner_total_q != '0, leader_id_q != runner_id_q, "leader is runner")
  `NLST_ASSERT_SAME(a_epoch_nonzero, 1'b1, epoch_q != '0, "epoch tag zero")
  `NLST_ASSERT_NEXT(a_move_result, (state_q == ST_CHECK) && out_free, out_valid_q, "move result lost")

endmodule
